// ===== rtl/core/kmp_pkg.sv =====
// Shared types and constants for the streaming KMP matcher.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none

package kmp_pkg;

    // Defaults for the top-level parameters.
    localparam int PATTERN_DEPTH_DEF  = 64;
    localparam int POSITION_WIDTH_DEF = 32;

    // Fixed field widths of the stream channels.
    localparam int CMD_W         = 2;
    localparam int BYTE_W        = 8;
    localparam int LEN_OUT_W     = 7;
    localparam int START_OUT_W   = 32;
    localparam int STATUS_W      = 2;
    localparam int M_TDATA_W     = 40;  // 7 + 32 bits, padded to whole bytes
    localparam int M_TUSER_W     = 3;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_APPEND  = 2'd1,
        CMD_TEXT    = 2'd2,
        CMD_RESTART = 2'd3
    } kmp_cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } kmp_status_t;

    // Operation kinds after classification by the front.
    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_APPEND,
        OP_REJECT,
        OP_TEXT,
        OP_TEXT_EMPTY,
        OP_RESTART
    } kmp_op_kind_t;

    typedef struct packed {
        kmp_op_kind_t        kind;
        logic [BYTE_W-1:0]   data;
    } kmp_op_t;

    typedef enum logic {
        BK_IDLE,
        BK_SEARCH
    } kmp_back_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/kmp_front.sv =====
// Front end of the KMP matcher: takes requests and classifies them.
// Tracks its own copy of the pattern length; depends on kmp_pkg.
`default_nettype none

module kmp_front #(
    parameter int PATTERN_DEPTH = kmp_pkg::PATTERN_DEPTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [kmp_pkg::BYTE_W-1:0] s_data,
    input  logic [kmp_pkg::CMD_W-1:0]  s_cmd,
    input  logic                      q_full,
    output logic                      push,
    output kmp_pkg::kmp_op_t          push_op
);
    import kmp_pkg::*;

    localparam int LEN_W = $clog2(PATTERN_DEPTH + 1);
    localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(PATTERN_DEPTH);

    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    always_comb begin
        len_next     = len_reg;
        push_op.data = s_data;
        push_op.kind = OP_RESTART;
        case (kmp_cmd_t'(s_cmd))
            CMD_CLEAR: begin
                push_op.kind = OP_CLEAR;
                if (push) begin
                    len_next = '0;
                end
            end
            CMD_APPEND: begin
                if (len_reg >= LEN_FULL) begin
                    push_op.kind = OP_REJECT;
                end else begin
                    push_op.kind = OP_APPEND;
                    if (push) begin
                        len_next = len_reg + LEN_W'(1);
                    end
                end
            end
            CMD_TEXT: begin
                push_op.kind = (len_reg == '0) ? OP_TEXT_EMPTY : OP_TEXT;
            end
            CMD_RESTART: begin
                push_op.kind = OP_RESTART;
            end
            default: begin
                push_op.kind = OP_RESTART;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
        end else begin
            len_reg <= len_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/kmp_queue.sv =====
// Short flip-flop queue of classified operations between front and back.
// One push while not full and one pop per cycle; depends on kmp_pkg.
`default_nettype none

module kmp_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  kmp_pkg::kmp_op_t push_op,
    output logic             full,
    output logic             head_valid,
    output kmp_pkg::kmp_op_t head_op,
    input  logic             pop
);
    import kmp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    kmp_op_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_op    = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/kmp_back.sv =====
// Back end of the KMP matcher: pattern and failure memories, the
// fallback sequencer and the result register. Depends on kmp_pkg.
`default_nettype none

module kmp_back #(
    parameter int PATTERN_DEPTH  = kmp_pkg::PATTERN_DEPTH_DEF,
    parameter int POSITION_WIDTH = kmp_pkg::POSITION_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            head_valid,
    input  kmp_pkg::kmp_op_t                head_op,
    output logic                            pop,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [kmp_pkg::LEN_OUT_W-1:0]   m_matched_length,
    output logic                            m_match_found,
    output logic [kmp_pkg::START_OUT_W-1:0] m_match_start,
    output logic [kmp_pkg::STATUS_W-1:0]    m_status
);
    import kmp_pkg::*;

    localparam int IDX_W = $clog2(PATTERN_DEPTH);
    localparam int LEN_W = $clog2(PATTERN_DEPTH + 1);
    localparam int PW    = POSITION_WIDTH;

    // Pattern and failure memories.
    logic [BYTE_W-1:0] pat_mem  [PATTERN_DEPTH];
    logic [IDX_W-1:0]  fail_mem [PATTERN_DEPTH];

    kmp_back_state_t   state_reg, state_next;
    kmp_op_t           item_reg, item_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [IDX_W-1:0]  bp_reg, bp_next;
    logic [IDX_W-1:0]  tp_reg, tp_next;
    logic [PW-1:0]     pos_reg, pos_next;
    logic [IDX_W-1:0]  k_reg, k_next;

    logic [BYTE_W-1:0] pat_rd_reg;
    logic [IDX_W-1:0]  fail_rd_reg;
    logic [IDX_W-1:0]  fail_last_rd_reg;

    logic              out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]  len_out_reg, len_out_next;
    logic              found_reg, found_next;
    logic [PW-1:0]     start_reg, start_next;
    kmp_status_t       status_reg, status_next;

    logic              out_free;
    logic              emit;
    logic              hit;
    logic [IDX_W-1:0]  last_idx;
    logic [IDX_W-1:0]  k_inc;
    logic [IDX_W-1:0]  k_fin;
    logic [IDX_W-1:0]  fail_addr;
    logic [IDX_W-1:0]  wr_idx;
    logic              wr_en;
    logic [BYTE_W-1:0] wr_pat;
    logic [IDX_W-1:0]  wr_fail;

    assign out_free = !out_valid_reg || m_ready;
    assign hit      = (pat_rd_reg == item_reg.data);
    assign last_idx = (len_reg == '0) ? '0 : IDX_W'(len_reg - LEN_W'(1));
    assign k_inc    = k_reg + IDX_W'(1);
    assign wr_idx   = IDX_W'(len_reg);

    always_comb begin
        state_next     = state_reg;
        item_next      = item_reg;
        len_next       = len_reg;
        bp_next        = bp_reg;
        tp_next        = tp_reg;
        pos_next       = pos_reg;
        k_next         = k_reg;
        pop            = 1'b0;
        emit           = 1'b0;
        len_out_next   = '0;
        found_next     = 1'b0;
        start_next     = '0;
        status_next    = ST_OK;
        wr_en          = 1'b0;
        wr_pat         = item_reg.data;
        wr_fail        = '0;
        k_fin          = '0;

        case (state_reg)
            BK_IDLE: begin
                if (head_valid && out_free) begin
                    pop       = 1'b1;
                    item_next = head_op;
                    case (head_op.kind)
                        OP_CLEAR: begin
                            emit     = 1'b1;
                            len_next = '0;
                            bp_next  = '0;
                            tp_next  = '0;
                            pos_next = '0;
                        end
                        OP_RESTART: begin
                            emit     = 1'b1;
                            tp_next  = '0;
                            pos_next = '0;
                        end
                        OP_REJECT: begin
                            emit        = 1'b1;
                            status_next = ST_FULL;
                        end
                        OP_TEXT_EMPTY: begin
                            emit        = 1'b1;
                            status_next = ST_EMPTY;
                        end
                        OP_APPEND: begin
                            if (len_reg == '0) begin
                                // First byte: no search, its failure value is zero.
                                emit     = 1'b1;
                                wr_en    = 1'b1;
                                wr_pat   = head_op.data;
                                wr_fail  = '0;
                                bp_next  = '0;
                                len_next = LEN_W'(1);
                                tp_next  = '0;
                                pos_next = '0;
                            end else begin
                                k_next     = bp_reg;
                                state_next = BK_SEARCH;
                            end
                        end
                        OP_TEXT: begin
                            k_next     = tp_reg;
                            state_next = BK_SEARCH;
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            BK_SEARCH: begin
                if (hit || k_reg == '0) begin
                    if (out_free) begin
                        emit       = 1'b1;
                        state_next = BK_IDLE;
                        if (item_reg.kind == OP_APPEND) begin
                            k_fin    = hit ? k_inc : '0;
                            wr_en    = 1'b1;
                            wr_fail  = k_fin;
                            bp_next  = k_fin;
                            len_next = len_reg + LEN_W'(1);
                            tp_next  = '0;
                            pos_next = '0;
                        end else begin
                            if (hit) begin
                                if (k_reg == last_idx) begin
                                    found_next = 1'b1;
                                    start_next = pos_reg - PW'(k_reg);
                                    k_fin = (fail_last_rd_reg > last_idx) ? '0
                                                                          : fail_last_rd_reg;
                                end else begin
                                    k_fin = k_inc;
                                end
                            end
                            tp_next      = k_fin;
                            len_out_next = k_fin;
                            pos_next     = pos_reg + PW'(1);
                        end
                    end
                end else begin
                    // Mismatch: follow one failure link.
                    k_next = (fail_rd_reg < k_reg) ? fail_rd_reg : '0;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase

        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign fail_addr = (k_next == '0) ? '0 : k_next - IDX_W'(1);

    // Memories: one write port, registered reads.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            pat_mem[wr_idx]  <= wr_pat;
            fail_mem[wr_idx] <= wr_fail;
        end
        pat_rd_reg       <= pat_mem[k_next];
        fail_rd_reg      <= fail_mem[fail_addr];
        fail_last_rd_reg <= fail_mem[last_idx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            len_reg       <= '0;
            bp_reg        <= '0;
            tp_reg        <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            bp_reg        <= bp_next;
            tp_reg        <= tp_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        k_reg    <= k_next;
        if (emit) begin
            len_out_reg <= len_out_next;
            found_reg   <= found_next;
            start_reg   <= start_next;
            status_reg  <= status_next;
        end
    end

    logic [IDX_W+LEN_OUT_W-1:0] len_ext;
    logic [PW+START_OUT_W-1:0]  start_ext;

    assign len_ext          = {{LEN_OUT_W{1'b0}}, len_out_reg};
    assign start_ext        = {{START_OUT_W{1'b0}}, start_reg};
    assign m_valid          = out_valid_reg;
    assign m_matched_length = len_ext[LEN_OUT_W-1:0];
    assign m_match_found    = found_reg;
    assign m_match_start    = start_ext[START_OUT_W-1:0];
    assign m_status         = status_reg;

    // An empty pattern leaves no prefix state behind.
    a_empty_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (len_reg == '0) |-> (tp_reg == '0 && bp_reg == '0))
        else $error("prefix state nonzero with empty pattern");

    // The search index always stays inside the stored pattern.
    a_k_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_SEARCH) |-> ({1'b0, k_reg} < {1'b0, len_reg}))
        else $error("search index beyond pattern length");

    // A match is only reported together with a good status.
    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && found_reg) |-> (status_reg == ST_OK))
        else $error("match reported with error status");

    // The pattern length never exceeds the memory depth.
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, len_reg} <= (LEN_W + 1)'(PATTERN_DEPTH)))
        else $error("pattern length overflow");

endmodule

`default_nettype wire

// ===== rtl/core/kmp_stream_matcher.sv =====
// Top level of the streaming Knuth-Morris-Pratt matcher.
// Instantiates kmp_front, kmp_queue and kmp_back; depends on kmp_pkg.
//
//   Channel | Direction | tdata                              | tuser
//   --------+-----------+------------------------------------+---------------------------
//   s_      | in        | [7:0] data_byte                    | [1:0] cmd
//   m_      | out       | [6:0] matched_length, [38:7] start | [0] match_found, [2:1] status
//
// Every request yields exactly one result. Clear, restart, rejected appends,
// text with an empty pattern and the first pattern byte are answered from the idle state.
// A text byte or a later pattern byte goes through the search state, which follows
// one failure link per mismatch; each link is one read of the failure memory.
// Over a stream the links followed stay at most one per byte on average.
// Reset (aresetn low, synchronous) empties the pattern, the text state and the
// queue. The front keeps accepting while the two-entry queue has room. The back
// takes the next request only when the result register is empty or is being
// read in that cycle, so a stalled result holds the back and the queue fills.
`default_nettype none

module kmp_stream_matcher #(
    parameter int PATTERN_DEPTH  = kmp_pkg::PATTERN_DEPTH_DEF,
    parameter int POSITION_WIDTH = kmp_pkg::POSITION_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Request channel.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [kmp_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] data_byte
    input  logic [kmp_pkg::CMD_W-1:0]     s_tuser,   // [1:0] cmd
    // Result channel.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [kmp_pkg::M_TDATA_W-1:0] m_tdata,   // [6:0] matched_length,
                                                     // [38:7] match_start, [39] zero
    output logic [kmp_pkg::M_TUSER_W-1:0] m_tuser    // [0] match_found, [2:1] status
);
    import kmp_pkg::*;

    logic                   q_full;
    logic                   push;
    kmp_op_t                push_op;
    logic                   head_valid;
    kmp_op_t                head_op;
    logic                   pop;
    logic [LEN_OUT_W-1:0]   res_len;
    logic                   res_found;
    logic [START_OUT_W-1:0] res_start;
    logic [STATUS_W-1:0]    res_status;

    // The front classifies each request against its own pattern length.
    kmp_front #(
        .PATTERN_DEPTH (PATTERN_DEPTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_data   (s_tdata),
        .s_cmd    (s_tuser),
        .q_full   (q_full),
        .push     (push),
        .push_op  (push_op)
    );

    kmp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_op    (push_op),
        .full       (q_full),
        .head_valid (head_valid),
        .head_op    (head_op),
        .pop        (pop)
    );

    // The back owns the memories and walks the failure links.
    kmp_back #(
        .PATTERN_DEPTH  (PATTERN_DEPTH),
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .head_valid       (head_valid),
        .head_op          (head_op),
        .pop              (pop),
        .m_valid          (m_tvalid),
        .m_ready          (m_tready),
        .m_matched_length (res_len),
        .m_match_found    (res_found),
        .m_match_start    (res_start),
        .m_status         (res_status)
    );

    assign m_tdata = {1'b0, res_start, res_len};
    assign m_tuser = {res_status, res_found};

endmodule

`default_nettype wire
